// ===== sv/slt_pkg.sv =====
package slt_pkg;

	// token kinds
	localparam logic [6:0] K_EOF      = 7'd0;
	localparam logic [6:0] K_ERROR    = 7'd1;
	localparam logic [6:0] K_IDENT    = 7'd2;
	localparam logic [6:0] K_INTEGER  = 7'd3;
	localparam logic [6:0] K_NUMBER   = 7'd4;
	localparam logic [6:0] K_STRING   = 7'd5;
	localparam logic [6:0] K_DOLLAR   = 7'd6;
	localparam logic [6:0] K_AT       = 7'd7;
	localparam logic [6:0] K_LPAREN   = 7'd8;
	localparam logic [6:0] K_RPAREN   = 7'd9;
	localparam logic [6:0] K_LBRACE   = 7'd10;
	localparam logic [6:0] K_RBRACE   = 7'd11;
	localparam logic [6:0] K_LBRACKET = 7'd12;
	localparam logic [6:0] K_RBRACKET = 7'd13;
	localparam logic [6:0] K_SEMI     = 7'd14;
	localparam logic [6:0] K_COMMA    = 7'd15;
	localparam logic [6:0] K_DOT      = 7'd16;
	localparam logic [6:0] K_ELLIPSIS = 7'd17;
	localparam logic [6:0] K_TILDE    = 7'd18;
	localparam logic [6:0] K_PERCENT  = 7'd19;
	localparam logic [6:0] K_COLON    = 7'd20;
	localparam logic [6:0] K_MINUS    = 7'd21;
	localparam logic [6:0] K_DEC      = 7'd22;
	localparam logic [6:0] K_SUB_EQ   = 7'd23;
	localparam logic [6:0] K_PLUS     = 7'd24;
	localparam logic [6:0] K_INC      = 7'd25;
	localparam logic [6:0] K_ADD_EQ   = 7'd26;
	localparam logic [6:0] K_SLASH    = 7'd27;
	localparam logic [6:0] K_STAR     = 7'd28;
	localparam logic [6:0] K_AMP      = 7'd29;
	localparam logic [6:0] K_AND      = 7'd30;
	localparam logic [6:0] K_PIPE     = 7'd31;
	localparam logic [6:0] K_OR       = 7'd32;
	localparam logic [6:0] K_BANG     = 7'd33;
	localparam logic [6:0] K_NE       = 7'd34;
	localparam logic [6:0] K_ASSIGN   = 7'd35;
	localparam logic [6:0] K_EQ       = 7'd36;
	localparam logic [6:0] K_LT       = 7'd37;
	localparam logic [6:0] K_LE       = 7'd38;
	localparam logic [6:0] K_SHL      = 7'd39;
	localparam logic [6:0] K_GT       = 7'd40;
	localparam logic [6:0] K_GE       = 7'd41;
	localparam logic [6:0] K_SHR      = 7'd42;

	// error kinds
	localparam logic [1:0] E_NONE   = 2'd0;
	localparam logic [1:0] E_UNEXP  = 2'd1;
	localparam logic [1:0] E_UNTERM = 2'd2;
	localparam logic [1:0] E_DDOT   = 2'd3;

	localparam int OFFSET_BITS_DEF  = 32;
	localparam int PREFIX_DEPTH_DEF = 8;
	localparam int KW_COUNT         = 29;
	localparam int KW_MAX_LEN       = 8;
	localparam logic [15:0] LEN_CAP  = 16'hFFFF;
	localparam logic [23:0] LINE_CAP = 24'hFFFFFF;

	typedef struct packed {
		logic [6:0]  kind;
		logic [1:0]  err;
		logic [31:0] off;
		logic [15:0] len;
		logic [23:0] line;
	} rec_t;

	typedef struct packed {
		rec_t rec;
		logic last;
	} out_entry_t;

	typedef struct packed {
		logic [3:0]  len;
		logic [63:0] txt;
		logic [6:0]  kind;
	} kw_t;

	// keyword text right aligned, first character most significant
	localparam kw_t KW_TABLE [KW_COUNT] = '{
		'{4'd3, 64'("and"), 7'd30},      '{4'd5, 64'("break"), 7'd43},
		'{4'd4, 64'("case"), 7'd44},     '{4'd5, 64'("catch"), 7'd45},
		'{4'd5, 64'("class"), 7'd46},    '{4'd8, 64'("continue"), 7'd47},
		'{4'd6, 64'("delete"), 7'd48},   '{4'd2, 64'("do"), 7'd49},
		'{4'd4, 64'("else"), 7'd50},     '{4'd6, 64'("extern"), 7'd51},
		'{4'd5, 64'("false"), 7'd52},    '{4'd7, 64'("finally"), 7'd53},
		'{4'd3, 64'("for"), 7'd54},      '{4'd3, 64'("fun"), 7'd55},
		'{4'd2, 64'("if"), 7'd56},       '{4'd3, 64'("isa"), 7'd57},
		'{4'd3, 64'("nil"), 7'd58},      '{4'd2, 64'("or"), 7'd32},
		'{4'd5, 64'("print"), 7'd59},    '{4'd6, 64'("return"), 7'd60},
		'{4'd6, 64'("static"), 7'd61},   '{4'd5, 64'("super"), 7'd62},
		'{4'd6, 64'("switch"), 7'd63},   '{4'd4, 64'("this"), 7'd64},
		'{4'd5, 64'("throw"), 7'd65},    '{4'd4, 64'("true"), 7'd66},
		'{4'd3, 64'("try"), 7'd67},      '{4'd3, 64'("var"), 7'd68},
		'{4'd5, 64'("while"), 7'd69}
	};

	function automatic logic is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_alpha(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic logic is_hex(logic [7:0] c);
		return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	// one-character tokens; anything else that starts no token is an error
	function automatic logic [6:0] single_kind(logic [7:0] c);
		logic [6:0] k;
		case (c)
			"$": k = K_DOLLAR;
			"@": k = K_AT;
			"(": k = K_LPAREN;
			")": k = K_RPAREN;
			"{": k = K_LBRACE;
			"}": k = K_RBRACE;
			"[": k = K_LBRACKET;
			"]": k = K_RBRACKET;
			";": k = K_SEMI;
			",": k = K_COMMA;
			"~": k = K_TILDE;
			"%": k = K_PERCENT;
			":": k = K_COLON;
			"*": k = K_STAR;
			default: k = K_ERROR;
		endcase
		return k;
	endfunction

endpackage

// ===== sv/slt_in_if.sv =====
interface slt_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;
	logic       end_of_input;

	modport source (output valid, output char_byte, output end_of_input, input ready);
	modport sink (input valid, input char_byte, input end_of_input, output ready);
endinterface

// ===== sv/slt_out_if.sv =====
interface slt_out_if;
	logic        valid;
	logic        ready;
	logic [6:0]  token_kind;
	logic [1:0]  error_kind;
	logic [31:0] token_offset;
	logic [15:0] token_length;
	logic [23:0] line_number;
	logic        run_last;

	modport source (output valid, output token_kind, output error_kind, output token_offset,
		output token_length, output line_number, output run_last, input ready);
	modport sink (input valid, input token_kind, input error_kind, input token_offset,
		input token_length, input line_number, input run_last, output ready);
endinterface

// ===== sv/script_lexer_tokenizer.sv =====
// output: a token is written into the result queue when the byte that ends it is accepted
// throughput: one byte per cycle while the four-entry result queue holds at most one token;
// a byte that ends up to three tokens drains them one per cycle while the receiver is ready
// reset: asynchronous, active low; scanner idle at offset 0, line 1, queue empty
// end of input flushes the pending token, emits eof and returns to the reset state
module script_lexer_tokenizer #(
	parameter int OFFSET_BITS  = slt_pkg::OFFSET_BITS_DEF,
	parameter int PREFIX_DEPTH = slt_pkg::PREFIX_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	slt_in_if.sink    chars,
	slt_out_if.source tokens
);
	import slt_pkg::*;

	localparam int IW    = $clog2(PREFIX_DEPTH);
	localparam int DEPTH = 4;

	typedef enum logic [22:0] {
		M_IDLE       = 23'(1) << 0,
		M_IDENT      = 23'(1) << 1,
		M_NUM_FIRST  = 23'(1) << 2,
		M_NUM_INT    = 23'(1) << 3,
		M_NUM_DOT    = 23'(1) << 4,
		M_NUM_FRAC   = 23'(1) << 5,
		M_HEX        = 23'(1) << 6,
		M_STRING     = 23'(1) << 7,
		M_STR_ESC    = 23'(1) << 8,
		M_LINE       = 23'(1) << 9,
		M_BLOCK      = 23'(1) << 10,
		M_BLOCK_STAR = 23'(1) << 11,
		M_SLASH      = 23'(1) << 12,
		M_DOT1       = 23'(1) << 13,
		M_DOT2       = 23'(1) << 14,
		M_MINUS      = 23'(1) << 15,
		M_PLUS       = 23'(1) << 16,
		M_AMP        = 23'(1) << 17,
		M_PIPE       = 23'(1) << 18,
		M_BANG       = 23'(1) << 19,
		M_EQ         = 23'(1) << 20,
		M_LT         = 23'(1) << 21,
		M_GT         = 23'(1) << 22
	} mode_t;

	typedef struct packed {
		mode_t                   mode;
		logic [OFFSET_BITS-1:0]  tb;
		logic [23:0]             line;
		logic [15:0]             wlen;
	} ctl_t;

	typedef struct packed {
		ctl_t                         ctl;
		logic [PREFIX_DEPTH-1:0][7:0] pfx;
	} st_t;

	typedef struct packed {
		st_t  st;
		logic em;
		rec_t rec;
		logic again;
	} pass_t;

	ctl_t                         ctl_q;
	logic [PREFIX_DEPTH-1:0][7:0] pfx_q;
	logic [OFFSET_BITS-1:0]       pos_q;
	out_entry_t                   fifo_q [DEPTH];
	logic [1:0]                   rd_q, wr_q;
	logic [2:0]                   cnt_q;

	function automatic logic [15:0] sat_len(logic [15:0] a, logic [1:0] k);
		logic [16:0] s;
		s = {1'b0, a} + 17'(k);
		return s[16] ? LEN_CAP : s[15:0];
	endfunction

	function automatic logic [23:0] line_inc(logic [23:0] l);
		return (l < LINE_CAP) ? l + 24'd1 : l;
	endfunction

	function automatic rec_t mk(logic [6:0] k, logic [1:0] e, logic [OFFSET_BITS-1:0] off,
			logic [15:0] len, logic [23:0] line);
		rec_t r;
		r.kind = k;
		r.err  = e;
		r.off  = 32'(off);
		r.len  = len;
		r.line = line;
		return r;
	endfunction

	// keyword lookup over the stored prefix
	function automatic logic [6:0] word_kind(st_t s);
		logic [63:0] w;
		logic [6:0]  k;
		w = '0;
		k = K_IDENT;
		for (int j = 0; j < KW_MAX_LEN; j++) begin
			if (16'(j) < s.ctl.wlen) w = {w[55:0], s.pfx[j]};
		end
		if (s.ctl.wlen <= 16'(KW_MAX_LEN)) begin
			for (int i = 0; i < KW_COUNT; i++) begin
				if (16'(KW_TABLE[i].len) == s.ctl.wlen && KW_TABLE[i].txt == w)
					k = KW_TABLE[i].kind;
			end
		end
		return k;
	endfunction

	// operators that may take a second character
	function automatic void pair_info(mode_t m, output logic [6:0] ks, output logic [7:0] c1,
			output logic [6:0] k1, output logic h2, output logic [7:0] c2,
			output logic [6:0] k2);
		h2 = 1'b0;
		c2 = "=";
		k2 = K_SUB_EQ;
		case (m)
			M_MINUS: begin ks = K_MINUS; c1 = "-"; k1 = K_DEC; h2 = 1'b1; end
			M_PLUS: begin ks = K_PLUS; c1 = "+"; k1 = K_INC; h2 = 1'b1; k2 = K_ADD_EQ; end
			M_AMP: begin ks = K_AMP; c1 = "&"; k1 = K_AND; end
			M_PIPE: begin ks = K_PIPE; c1 = "|"; k1 = K_OR; end
			M_BANG: begin ks = K_BANG; c1 = "="; k1 = K_NE; end
			M_EQ: begin ks = K_ASSIGN; c1 = "="; k1 = K_EQ; end
			M_LT: begin ks = K_LT; c1 = "="; k1 = K_LE; h2 = 1'b1; c2 = "<"; k2 = K_SHL; end
			default: begin ks = K_GT; c1 = "="; k1 = K_GE; h2 = 1'b1; c2 = ">"; k2 = K_SHR; end
		endcase
	endfunction

	// one step of the scanner; again asks for the byte to be looked at once more
	function automatic pass_t scan_pass(st_t s, logic [7:0] c, logic [OFFSET_BITS-1:0] pos);
		pass_t      r;
		logic [6:0] ks, k1, k2, sk;
		logic [7:0] c1, c2;
		logic       h2;
		r.st    = s;
		r.em    = 1'b0;
		r.rec   = '0;
		r.again = 1'b0;
		case (s.ctl.mode)
			M_IDLE: begin
				r.st.ctl.tb   = pos;
				r.st.ctl.wlen = 16'd1;
				sk = single_kind(c);
				if (c == " " || c == 8'h0D || c == 8'h09) begin
				end else if (c == 8'h0A) begin
					r.st.ctl.line = line_inc(s.ctl.line);
				end else if (c == "#") begin
					r.st.ctl.mode = M_LINE;
				end else if (is_alpha(c)) begin
					r.st.pfx[0]   = c;
					r.st.ctl.mode = M_IDENT;
				end else if (is_digit(c)) begin
					r.st.ctl.mode = M_NUM_FIRST;
				end else if (c == "\"") begin
					r.st.ctl.mode = M_STRING;
				end else if (c == "/") begin
					r.st.ctl.mode = M_SLASH;
				end else if (c == ".") begin
					r.st.ctl.mode = M_DOT1;
				end else if (c == "-") begin
					r.st.ctl.mode = M_MINUS;
				end else if (c == "+") begin
					r.st.ctl.mode = M_PLUS;
				end else if (c == "&") begin
					r.st.ctl.mode = M_AMP;
				end else if (c == "|") begin
					r.st.ctl.mode = M_PIPE;
				end else if (c == "!") begin
					r.st.ctl.mode = M_BANG;
				end else if (c == "=") begin
					r.st.ctl.mode = M_EQ;
				end else if (c == "<") begin
					r.st.ctl.mode = M_LT;
				end else if (c == ">") begin
					r.st.ctl.mode = M_GT;
				end else begin
					r.em  = 1'b1;
					r.rec = mk(sk, (sk == K_ERROR) ? E_UNEXP : E_NONE, pos, 16'd1, s.ctl.line);
				end
			end
			M_IDENT: begin
				if (is_alpha(c) || is_digit(c)) begin
					if (s.ctl.wlen < 16'(PREFIX_DEPTH)) r.st.pfx[s.ctl.wlen[IW-1:0]] = c;
					r.st.ctl.wlen = sat_len(s.ctl.wlen, 2'd1);
				end else begin
					r.em  = 1'b1;
					r.rec = mk(word_kind(s), E_NONE, s.ctl.tb, s.ctl.wlen, s.ctl.line);
					r.st.ctl.mode = M_IDLE;
					r.again = 1'b1;
				end
			end
			M_NUM_FIRST, M_NUM_INT: begin
				if (s.ctl.mode == M_NUM_FIRST && (c == "x" || c == "X")) begin
					r.st.ctl.wlen = sat_len(s.ctl.wlen, 2'd1);
					r.st.ctl.mode = M_HEX;
				end else if (is_digit(c)) begin
					r.st.ctl.wlen = sat_len(s.ctl.wlen, 2'd1);
					r.st.ctl.mode = M_NUM_INT;
				end else if (c == ".") begin
					r.st.ctl.mode = M_NUM_DOT;
				end else begin
					r.em  = 1'b1;
					r.rec = mk(K_INTEGER, E_NONE, s.ctl.tb, s.ctl.wlen, s.ctl.line);
					r.st.ctl.mode = M_IDLE;
					r.again = 1'b1;
				end
			end
			M_NUM_DOT: begin
				if (is_digit(c)) begin
					r.st.ctl.wlen = sat_len(s.ctl.wlen, 2'd2);
					r.st.ctl.mode = M_NUM_FRAC;
				end else begin
					// integer ends, the held dot starts its own token
					r.em  = 1'b1;
					r.rec = mk(K_INTEGER, E_NONE, s.ctl.tb, s.ctl.wlen, s.ctl.line);
					r.st.ctl.tb   = pos - OFFSET_BITS'(1);
					r.st.ctl.wlen = 16'd1;
					r.st.ctl.mode = M_DOT1;
					r.again = 1'b1;
				end
			end
			M_NUM_FRAC, M_HEX: begin
				if (s.ctl.mode == M_HEX ? is_hex(c) : is_digit(c)) begin
					r.st.ctl.wlen = sat_len(s.ctl.wlen, 2'd1);
				end else begin
					r.em  = 1'b1;
					r.rec = mk((s.ctl.mode == M_HEX) ? K_INTEGER : K_NUMBER, E_NONE, s.ctl.tb,
						s.ctl.wlen, s.ctl.line);
					r.st.ctl.mode = M_IDLE;
					r.again = 1'b1;
				end
			end
			M_STRING: begin
				r.st.ctl.wlen = sat_len(s.ctl.wlen, 2'd1);
				if (c == "\"") begin
					r.em  = 1'b1;
					r.rec = mk(K_STRING, E_NONE, s.ctl.tb, r.st.ctl.wlen, s.ctl.line);
					r.st.ctl.mode = M_IDLE;
				end else if (c == "\\") begin
					r.st.ctl.mode = M_STR_ESC;
				end else if (c == 8'h0A) begin
					r.st.ctl.line = line_inc(s.ctl.line);
				end
			end
			M_STR_ESC: begin
				r.st.ctl.wlen = sat_len(s.ctl.wlen, 2'd1);
				if (c == 8'h0A) r.st.ctl.line = line_inc(s.ctl.line);
				r.st.ctl.mode = M_STRING;
			end
			M_LINE: begin
				if (c == 8'h0A) begin
					r.st.ctl.line = line_inc(s.ctl.line);
					r.st.ctl.mode = M_IDLE;
				end
			end
			M_BLOCK, M_BLOCK_STAR: begin
				if (c == 8'h0A) r.st.ctl.line = line_inc(s.ctl.line);
				if (s.ctl.mode == M_BLOCK_STAR && c == "/") r.st.ctl.mode = M_IDLE;
				else r.st.ctl.mode = (c == "*") ? M_BLOCK_STAR : M_BLOCK;
			end
			M_SLASH: begin
				if (c == "/") begin
					r.st.ctl.mode = M_LINE;
				end else if (c == "*") begin
					r.st.ctl.mode = M_BLOCK;
				end else begin
					r.em  = 1'b1;
					r.rec = mk(K_SLASH, E_NONE, s.ctl.tb, s.ctl.wlen, s.ctl.line);
					r.st.ctl.mode = M_IDLE;
					r.again = 1'b1;
				end
			end
			M_DOT1: begin
				if (c == ".") begin
					r.st.ctl.wlen = 16'd2;
					r.st.ctl.mode = M_DOT2;
				end else begin
					r.em  = 1'b1;
					r.rec = mk(K_DOT, E_NONE, s.ctl.tb, s.ctl.wlen, s.ctl.line);
					r.st.ctl.mode = M_IDLE;
					r.again = 1'b1;
				end
			end
			M_DOT2: begin
				r.em = 1'b1;
				r.st.ctl.mode = M_IDLE;
				if (c == ".") begin
					r.st.ctl.wlen = 16'd3;
					r.rec = mk(K_ELLIPSIS, E_NONE, s.ctl.tb, 16'd3, s.ctl.line);
				end else begin
					r.rec = mk(K_ERROR, E_DDOT, s.ctl.tb, s.ctl.wlen, s.ctl.line);
					r.again = 1'b1;
				end
			end
			default: begin
				pair_info(s.ctl.mode, ks, c1, k1, h2, c2, k2);
				r.em = 1'b1;
				r.st.ctl.mode = M_IDLE;
				if (c == c1 || (h2 && c == c2)) begin
					r.st.ctl.wlen = 16'd2;
					r.rec = mk((c == c1) ? k1 : k2, E_NONE, s.ctl.tb, 16'd2, s.ctl.line);
				end else begin
					r.rec = mk(ks, E_NONE, s.ctl.tb, s.ctl.wlen, s.ctl.line);
					r.again = 1'b1;
				end
			end
		endcase
		return r;
	endfunction

	// scan passes for the incoming byte
	st_t   cur;
	pass_t p1, p2, p3;
	logic  do_acc, do_pop;
	rec_t  cand [3];
	logic  cand_v [3];
	rec_t  outr [3];
	logic  [1:0] nres;
	st_t   nxt;
	logic  [6:0] fks, fk1, fk2;
	logic  [7:0] fc1, fc2;
	logic        fh2;

	assign cur.ctl = ctl_q;
	assign cur.pfx = pfx_q;

	always_comb begin
		p1 = scan_pass(cur, chars.char_byte, pos_q);
		p2 = p1;
		p2.em = 1'b0;
		p2.again = 1'b0;
		if (p1.again) p2 = scan_pass(p1.st, chars.char_byte, pos_q);
		p3 = p2;
		p3.em = 1'b0;
		p3.again = 1'b0;
		if (p2.again) p3 = scan_pass(p2.st, chars.char_byte, pos_q);
	end

	// candidate results: either the flush at end of input or the scan passes
	always_comb begin
		pair_info(ctl_q.mode, fks, fc1, fk1, fh2, fc2, fk2);
		for (int i = 0; i < 3; i++) begin
			cand[i]   = '0;
			cand_v[i] = 1'b0;
		end
		nxt = p3.st;
		if (chars.end_of_input) begin
			nxt.ctl.mode = M_IDLE;
			nxt.ctl.tb   = '0;
			nxt.ctl.line = 24'd1;
			nxt.ctl.wlen = '0;
			nxt.pfx      = pfx_q;
			cand_v[0] = 1'b1;
			cand[0]   = mk(K_INTEGER, E_NONE, ctl_q.tb, ctl_q.wlen, ctl_q.line);
			cand_v[2] = 1'b1;
			cand[2]   = mk(K_EOF, E_NONE, pos_q, 16'd0, ctl_q.line);
			case (ctl_q.mode)
				M_IDENT: cand[0].kind = word_kind(cur);
				M_NUM_FIRST, M_NUM_INT, M_HEX: begin
				end
				M_NUM_FRAC: cand[0].kind = K_NUMBER;
				M_NUM_DOT: begin
					cand_v[1] = 1'b1;
					cand[1]   = mk(K_DOT, E_NONE, pos_q - OFFSET_BITS'(1), 16'd1, ctl_q.line);
				end
				M_STRING, M_STR_ESC: begin
					cand[0].kind = K_ERROR;
					cand[0].err  = E_UNTERM;
				end
				M_SLASH: cand[0].kind = K_SLASH;
				M_DOT1: cand[0].kind = K_DOT;
				M_DOT2: begin
					cand[0].kind = K_ERROR;
					cand[0].err  = E_DDOT;
				end
				M_MINUS, M_PLUS, M_AMP, M_PIPE, M_BANG, M_EQ, M_LT, M_GT: cand[0].kind = fks;
				default: cand_v[0] = 1'b0;
			endcase
		end else begin
			cand_v[0] = p1.em;
			cand[0]   = p1.rec;
			cand_v[1] = p1.again & p2.em;
			cand[1]   = p2.rec;
			cand_v[2] = p1.again & p2.again & p3.em;
			cand[2]   = p3.rec;
		end
	end

	// pack the results in order
	always_comb begin
		nres = 2'd0;
		for (int i = 0; i < 3; i++) outr[i] = '0;
		for (int i = 0; i < 3; i++) begin
			if (cand_v[i]) begin
				outr[nres] = cand[i];
				nres = nres + 2'd1;
			end
		end
	end

	assign chars.ready = cnt_q <= 3'd1;
	assign do_acc = chars.valid & chars.ready;
	assign do_pop = tokens.valid & tokens.ready;

	// scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q.mode <= M_IDLE;
			ctl_q.tb   <= '0;
			ctl_q.line <= 24'd1;
			ctl_q.wlen <= '0;
			pos_q      <= '0;
		end else if (do_acc) begin
			ctl_q <= nxt.ctl;
			pos_q <= chars.end_of_input ? '0 : pos_q + OFFSET_BITS'(1);
		end
	end

	// word prefix store
	always_ff @(posedge clk) begin
		if (do_acc) pfx_q <= nxt.pfx;
	end

	// result queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			wr_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_pop) rd_q <= rd_q + 2'd1;
			if (do_acc) wr_q <= wr_q + nres;
			cnt_q <= cnt_q + (do_acc ? 3'(nres) : 3'd0) - (do_pop ? 3'd1 : 3'd0);
		end
	end

	always_ff @(posedge clk) begin
		if (do_acc) begin
			for (int i = 0; i < 3; i++) begin
				if (2'(i) < nres) begin
					fifo_q[wr_q + 2'(i)].rec  <= outr[i];
					fifo_q[wr_q + 2'(i)].last <= (2'(i) == nres - 2'd1);
				end
			end
		end
	end

	assign tokens.valid        = cnt_q != 3'd0;
	assign tokens.token_kind   = fifo_q[rd_q].rec.kind;
	assign tokens.error_kind   = fifo_q[rd_q].rec.err;
	assign tokens.token_offset = fifo_q[rd_q].rec.off;
	assign tokens.token_length = fifo_q[rd_q].rec.len;
	assign tokens.line_number  = fifo_q[rd_q].rec.line;
	assign tokens.run_last     = fifo_q[rd_q].last;

	// queue never overfills
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'(DEPTH)) else $error("result queue overflow");

	// end of input always leaves at least the eof token queued
	a_eof_queued: assert property (@(posedge clk) disable iff (!arst_n)
		do_acc && chars.end_of_input |=> cnt_q != 3'd0) else $error("eof token missing");

	// end of input restarts the scanner
	a_eof_reset: assert property (@(posedge clk) disable iff (!arst_n)
		do_acc && chars.end_of_input |=> pos_q == '0 && ctl_q.mode == M_IDLE
		&& ctl_q.line == 24'd1) else $error("scanner not restarted after eof");

endmodule

// ===== dv/script_lexer_tokenizer_test.sv =====
module script_lexer_tokenizer_test;
	timeunit 1ns;
	timeprecision 1ps;

	import slt_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_IDENT, S_NUM_FIRST, S_NUM_INT, S_NUM_DOT, S_NUM_FRAC, S_HEX,
		S_STRING, S_STR_ESC, S_LINE, S_BLOCK, S_BLOCK_STAR, S_SLASH, S_DOT1, S_DOT2,
		S_MINUS, S_PLUS, S_AMP, S_PIPE, S_BANG, S_EQ, S_LT, S_GT
	} scan_state_t;

	typedef struct {
		logic [6:0] single;
		logic [8:0] c1;
		logic [6:0] k1;
		logic [8:0] c2;
		logic [6:0] k2;
	} pair_t;

	typedef struct {
		logic [7:0] ch;
		logic       eoi;
		bit         drain_first;
	} src_item_t;

	localparam logic [8:0] NO_CHAR = 9'h100;
	localparam int IDLE_PCT = 12;
	localparam int HOLD_CYCLES = 200;
	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 10;

	logic clk;
	logic arst_n;

	slt_in_if  chars ();
	slt_out_if tokens ();

	script_lexer_tokenizer uut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars),
		.tokens (tokens)
	);

	// scanner copy used for prediction
	scan_state_t sc_mode;
	logic [31:0] sc_begin;
	logic [31:0] sc_pos;
	logic [23:0] sc_line;
	logic [7:0]  sc_prefix [PREFIX_DEPTH_DEF];
	int          sc_wlen;

	out_entry_t  token_q [$];
	src_item_t   src_q [$];
	int          bytes_in;
	int          fails;
	int          stall_cnt;
	int          hold_cnt;
	bit          hold_done;
	bit          in_taken;

	function automatic int len_add(int a, int k);
		return (a + k > 65535) ? 65535 : a + k;
	endfunction

	function automatic pair_t pair_of(scan_state_t m);
		pair_t p;
		case (m)
			S_MINUS: p = '{K_MINUS, 9'("-"), K_DEC, 9'("="), K_SUB_EQ};
			S_PLUS:  p = '{K_PLUS, 9'("+"), K_INC, 9'("="), K_ADD_EQ};
			S_AMP:   p = '{K_AMP, 9'("&"), K_AND, NO_CHAR, K_EOF};
			S_PIPE:  p = '{K_PIPE, 9'("|"), K_OR, NO_CHAR, K_EOF};
			S_BANG:  p = '{K_BANG, 9'("="), K_NE, NO_CHAR, K_EOF};
			S_EQ:    p = '{K_ASSIGN, 9'("="), K_EQ, NO_CHAR, K_EOF};
			S_LT:    p = '{K_LT, 9'("="), K_LE, 9'("<"), K_SHL};
			default: p = '{K_GT, 9'("="), K_GE, 9'(">"), K_SHR};
		endcase
		return p;
	endfunction

	function automatic logic [6:0] word_kind_of();
		bit hit;
		if (sc_wlen > PREFIX_DEPTH_DEF)
			return K_IDENT;
		for (int i = 0; i < KW_COUNT; i++) begin
			if (KW_TABLE[i].len != sc_wlen)
				continue;
			hit = 1;
			for (int j = 0; j < sc_wlen; j++)
				if (sc_prefix[j] != KW_TABLE[i].txt[8 * (sc_wlen - 1 - j) +: 8])
					hit = 0;
			if (hit)
				return KW_TABLE[i].kind;
		end
		return K_IDENT;
	endfunction

	task automatic push_token(logic [6:0] kind, logic [1:0] err, logic [31:0] off, int len);
		out_entry_t e;
		e.rec.kind = kind;
		e.rec.err  = err;
		e.rec.off  = off;
		e.rec.len  = 16'(len);
		e.rec.line = sc_line;
		e.last     = 1'b0;
		token_q.push_back(e);
	endtask

	task automatic push_cur(logic [6:0] kind, logic [1:0] err);
		push_token(kind, err, sc_begin, sc_wlen);
	endtask

	task automatic next_line();
		if (sc_line != LINE_CAP)
			sc_line++;
	endtask

	task automatic clear_scanner();
		sc_mode  = S_IDLE;
		sc_begin = '0;
		sc_pos   = '0;
		sc_line  = 24'd1;
		sc_wlen  = 0;
		foreach (sc_prefix[i])
			sc_prefix[i] = '0;
	endtask

	task automatic begin_token(logic [7:0] c, logic [31:0] p);
		logic [6:0] k;
		sc_begin = p;
		sc_wlen  = 1;
		if (c == " " || c == 8'h0d || c == 8'h09)
			return;
		if (c == 8'h0a) begin
			next_line();
			return;
		end
		if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_") begin
			sc_prefix[0] = c;
			sc_mode = S_IDENT;
			return;
		end
		if (c >= "0" && c <= "9") begin
			sc_mode = S_NUM_FIRST;
			return;
		end
		case (c)
			"#": sc_mode = S_LINE;
			"\"": sc_mode = S_STRING;
			"/": sc_mode = S_SLASH;
			".": sc_mode = S_DOT1;
			"-": sc_mode = S_MINUS;
			"+": sc_mode = S_PLUS;
			"&": sc_mode = S_AMP;
			"|": sc_mode = S_PIPE;
			"!": sc_mode = S_BANG;
			"=": sc_mode = S_EQ;
			"<": sc_mode = S_LT;
			">": sc_mode = S_GT;
			default: begin
				case (c)
					"$": k = K_DOLLAR;
					"@": k = K_AT;
					"(": k = K_LPAREN;
					")": k = K_RPAREN;
					"{": k = K_LBRACE;
					"}": k = K_RBRACE;
					"[": k = K_LBRACKET;
					"]": k = K_RBRACKET;
					";": k = K_SEMI;
					",": k = K_COMMA;
					"~": k = K_TILDE;
					"%": k = K_PERCENT;
					":": k = K_COLON;
					"*": k = K_STAR;
					default: k = K_ERROR;
				endcase
				push_cur(k, (k == K_ERROR) ? E_UNEXP : E_NONE);
			end
		endcase
	endtask

	// one source byte: may end a token and restart on the same byte
	task automatic scan_byte(logic [7:0] c);
		bit again;
		bit dig;
		pair_t pr;
		dig = (c >= "0" && c <= "9");
		again = 1;
		while (again) begin
			again = 0;
			case (sc_mode)
				S_IDLE: begin_token(c, sc_pos);
				S_IDENT: begin
					if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_" || dig) begin
						if (sc_wlen < PREFIX_DEPTH_DEF)
							sc_prefix[sc_wlen] = c;
						sc_wlen = len_add(sc_wlen, 1);
					end else begin
						push_cur(word_kind_of(), E_NONE);
						sc_mode = S_IDLE;
						again = 1;
					end
				end
				S_NUM_FIRST, S_NUM_INT: begin
					if (sc_mode == S_NUM_FIRST && (c == "x" || c == "X")) begin
						sc_wlen = len_add(sc_wlen, 1);
						sc_mode = S_HEX;
					end else if (dig) begin
						sc_wlen = len_add(sc_wlen, 1);
						sc_mode = S_NUM_INT;
					end else if (c == ".") begin
						sc_mode = S_NUM_DOT;
					end else begin
						push_cur(K_INTEGER, E_NONE);
						sc_mode = S_IDLE;
						again = 1;
					end
				end
				S_NUM_DOT: begin
					if (dig) begin
						sc_wlen = len_add(sc_wlen, 2);
						sc_mode = S_NUM_FRAC;
					end else begin
						// integer goes out, the held dot restarts at its own offset
						push_cur(K_INTEGER, E_NONE);
						sc_begin = sc_pos - 1;
						sc_wlen = 1;
						sc_mode = S_DOT1;
						again = 1;
					end
				end
				S_NUM_FRAC, S_HEX: begin
					if (sc_mode == S_HEX ? ((c >= "a" && c <= "f") || (c >= "A" && c <= "F") || dig)
							: dig) begin
						sc_wlen = len_add(sc_wlen, 1);
					end else begin
						push_cur(sc_mode == S_HEX ? K_INTEGER : K_NUMBER, E_NONE);
						sc_mode = S_IDLE;
						again = 1;
					end
				end
				S_STRING: begin
					sc_wlen = len_add(sc_wlen, 1);
					if (c == "\"") begin
						push_cur(K_STRING, E_NONE);
						sc_mode = S_IDLE;
					end else if (c == "\\") begin
						sc_mode = S_STR_ESC;
					end else if (c == 8'h0a) begin
						next_line();
					end
				end
				S_STR_ESC: begin
					sc_wlen = len_add(sc_wlen, 1);
					if (c == 8'h0a)
						next_line();
					sc_mode = S_STRING;
				end
				S_LINE: begin
					if (c == 8'h0a) begin
						next_line();
						sc_mode = S_IDLE;
					end
				end
				S_BLOCK, S_BLOCK_STAR: begin
					if (c == 8'h0a)
						next_line();
					if (sc_mode == S_BLOCK_STAR && c == "/")
						sc_mode = S_IDLE;
					else
						sc_mode = (c == "*") ? S_BLOCK_STAR : S_BLOCK;
				end
				S_SLASH: begin
					if (c == "/") begin
						sc_mode = S_LINE;
					end else if (c == "*") begin
						sc_mode = S_BLOCK;
					end else begin
						push_cur(K_SLASH, E_NONE);
						sc_mode = S_IDLE;
						again = 1;
					end
				end
				S_DOT1: begin
					if (c == ".") begin
						sc_wlen = 2;
						sc_mode = S_DOT2;
					end else begin
						push_cur(K_DOT, E_NONE);
						sc_mode = S_IDLE;
						again = 1;
					end
				end
				S_DOT2: begin
					if (c == ".") begin
						sc_wlen = 3;
						push_cur(K_ELLIPSIS, E_NONE);
					end else begin
						push_cur(K_ERROR, E_DDOT);
						again = 1;
					end
					sc_mode = S_IDLE;
				end
				default: begin
					pr = pair_of(sc_mode);
					if ({1'b0, c} == pr.c1 || {1'b0, c} == pr.c2) begin
						sc_wlen = 2;
						push_cur({1'b0, c} == pr.c1 ? pr.k1 : pr.k2, E_NONE);
					end else begin
						push_cur(pr.single, E_NONE);
						again = 1;
					end
					sc_mode = S_IDLE;
				end
			endcase
		end
		sc_pos = sc_pos + 1;
	endtask

	// end of input: pending token, then eof, then back to reset state
	task automatic scan_end();
		case (sc_mode)
			S_IDENT: push_cur(word_kind_of(), E_NONE);
			S_NUM_FIRST, S_NUM_INT, S_HEX: push_cur(K_INTEGER, E_NONE);
			S_NUM_FRAC: push_cur(K_NUMBER, E_NONE);
			S_NUM_DOT: begin
				push_cur(K_INTEGER, E_NONE);
				push_token(K_DOT, E_NONE, sc_pos - 1, 1);
			end
			S_STRING, S_STR_ESC: push_cur(K_ERROR, E_UNTERM);
			S_SLASH: push_cur(K_SLASH, E_NONE);
			S_DOT1: push_cur(K_DOT, E_NONE);
			S_DOT2: push_cur(K_ERROR, E_DDOT);
			S_MINUS, S_PLUS, S_AMP, S_PIPE, S_BANG, S_EQ, S_LT, S_GT:
				push_cur(pair_of(sc_mode).single, E_NONE);
			default: ;
		endcase
		push_token(K_EOF, E_NONE, sc_pos, 0);
		clear_scanner();
	endtask

	// stimulus builders
	task automatic add_byte(logic [7:0] c);
		src_q.push_back('{c, 1'b0, 1'b0});
	endtask

	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	task automatic add_eoi(bit drain);
		src_q.push_back('{8'($urandom), 1'b1, drain});
	endtask

	task automatic add_keyword(int i);
		for (int j = KW_TABLE[i].len - 1; j >= 0; j--)
			add_byte(KW_TABLE[i].txt[8 * j +: 8]);
	endtask

	function automatic logic [7:0] rand_alnum();
		case ($urandom_range(3))
			0: return 8'("a") + 8'($urandom_range(25));
			1: return 8'("A") + 8'($urandom_range(25));
			2: return 8'("0") + 8'($urandom_range(9));
			default: return 8'("_");
		endcase
	endfunction

	task automatic add_fragment();
		string ops [] = '{"-", "--", "-=", "+", "++", "+=", "&", "&&", "|", "||", "!", "!=",
			"=", "==", "<", "<=", "<<", ">", ">=", ">>", "/", "*", "$", "@", "(", ")", "{",
			"}", "[", "]", ";", ",", "~", "%", ":", ".", "..", "...", "#"};
		case ($urandom_range(11))
			0, 1: begin
				if ($urandom_range(2) == 0) begin
					add_keyword($urandom_range(KW_COUNT - 1));
				end else begin
					add_byte(8'("a") + 8'($urandom_range(25)));
					repeat ($urandom_range(10))
						add_byte(rand_alnum());
				end
			end
			2, 3: begin
				add_byte(8'("0") + 8'($urandom_range(9)));
				case ($urandom_range(4))
					0: add_byte($urandom_range(1) ? "x" : "X");
					1: add_byte(".");
					default: ;
				endcase
				repeat ($urandom_range(4))
					add_byte($urandom_range(3) == 0 ? 8'("a") + 8'($urandom_range(7))
						: 8'("0") + 8'($urandom_range(9)));
			end
			4: begin
				add_byte("\"");
				repeat ($urandom_range(6)) begin
					case ($urandom_range(5))
						0: add_text("\\\"");
						1: add_text("\\\\");
						2: add_byte(8'h0a);
						default: add_byte(8'($urandom_range(32, 126)));
					endcase
				end
				if ($urandom_range(7) != 0)
					add_byte("\"");
			end
			5: begin
				if ($urandom_range(1)) begin
					add_text($urandom_range(1) ? "//" : "#");
					repeat ($urandom_range(5))
						add_byte(8'($urandom_range(32, 126)));
					add_byte(8'h0a);
				end else begin
					add_text("/*");
					repeat ($urandom_range(6))
						add_byte($urandom_range(2) == 0 ? 8'("*") : 8'($urandom_range(10, 126)));
					add_text("*/");
				end
			end
			6, 7: add_text(ops[$urandom_range(ops.size() - 1)]);
			8: add_byte(8'($urandom));
			9: add_eoi($urandom_range(3) == 0);
			default: begin
				case ($urandom_range(3))
					0: add_byte(8'h0a);
					1: add_byte(8'h09);
					2: add_byte(8'h0d);
					default: add_byte(" ");
				endcase
			end
		endcase
		if ($urandom_range(2) == 0)
			add_byte($urandom_range(4) == 0 ? 8'h0a : 8'(" "));
	endtask

	// clock and reset
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		chars.valid = 1'b0;
		chars.char_byte = '0;
		chars.end_of_input = 1'b0;
		tokens.ready = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// stimulus and end of run
	initial begin
		fails = 0;
		clear_scanner();
		for (int i = 0; i < KW_COUNT; i++) begin
			add_keyword(i);
			add_byte(" ");
		end
		add_text("abcdefghij foo_Z9 0 123 5x3 12x 0x 0xfF 3.14 7. 7.a 1..2 ");
		add_text("\"a\\\\b\\\"c\" # c\n// d\n/* x\n*/ /*/ */ . .. ... ..x ");
		add_text("- -- -= + ++ += & && | || ! != = == < <= << > >= >> / * $@(){}[];,~%:");
		add_byte(8'h00);
		add_byte(8'h80);
		add_byte(8'hff);
		add_byte(8'h01);
		add_text("12.");
		add_eoi(1'b0);
		add_text("\"open");
		add_eoi(1'b1);
		add_text("/* open\n");
		add_eoi(1'b0);
		add_text("+");
		add_eoi(1'b0);
		while (src_q.size() < 430)
			add_fragment();
		add_eoi(1'b0);

		wait (src_q.size() == 0 && !chars.valid);
		wait (token_q.size() == 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fails == 0 && token_q.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// input transfers feed the predictor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_taken <= 1'b0;
			bytes_in <= 0;
		end else begin
			in_taken <= chars.valid && chars.ready;
			if (chars.valid && chars.ready) begin
				bytes_in <= bytes_in + 1;
				if (chars.end_of_input)
					scan_end();
				else
					scan_byte(chars.char_byte);
				if (token_q.size() > 0 && !token_q[$].last)
					token_q[$].last = 1'b1;
			end
		end
	end

	// driver
	always @(negedge clk) begin
		logic nv;
		bit calm;
		if (arst_n) begin
			nv = chars.valid && !in_taken;
			calm = bytes_in > 150 && bytes_in < 250;
			if (!nv && src_q.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)
					&& !(src_q[0].drain_first && token_q.size() != 0)) begin
				chars.char_byte <= src_q[0].ch;
				chars.end_of_input <= src_q[0].eoi;
				void'(src_q.pop_front());
				nv = 1'b1;
			end
			chars.valid <= nv;
		end
	end

	// receiver, with one long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (!hold_done && bytes_in > 300) begin
				hold_done <= 1'b1;
				hold_cnt <= HOLD_CYCLES;
				tokens.ready <= 1'b0;
			end else if (hold_cnt > 0) begin
				hold_cnt <= hold_cnt - 1;
				tokens.ready <= 1'b0;
			end else begin
				tokens.ready <= (bytes_in > 150 && bytes_in < 250)
					|| $urandom_range(99) >= IDLE_PCT;
			end
		end
	end

	initial begin
		hold_done = 1'b0;
		hold_cnt = 0;
	end

	// monitor: compare each token transfer against the oldest prediction
	always @(posedge clk) begin
		out_entry_t e;
		if (arst_n && tokens.valid && tokens.ready) begin
			if (token_q.size() == 0) begin
				$error("token with none predicted: kind %0d", tokens.token_kind);
				fails++;
			end else begin
				e = token_q.pop_front();
				if (tokens.token_kind !== e.rec.kind) begin
					$error("token_kind expected %0d actual %0d", e.rec.kind, tokens.token_kind);
					fails++;
				end
				if (tokens.error_kind !== e.rec.err) begin
					$error("error_kind expected %0d actual %0d", e.rec.err, tokens.error_kind);
					fails++;
				end
				if (tokens.token_offset !== e.rec.off) begin
					$error("token_offset expected %0d actual %0d", e.rec.off,
						tokens.token_offset);
					fails++;
				end
				if (tokens.token_length !== e.rec.len) begin
					$error("token_length expected %0d actual %0d", e.rec.len,
						tokens.token_length);
					fails++;
				end
				if (tokens.line_number !== e.rec.line) begin
					$error("line_number expected %0d actual %0d", e.rec.line,
						tokens.line_number);
					fails++;
				end
				if (tokens.run_last !== e.last) begin
					$error("run_last expected %0d actual %0d", e.last, tokens.run_last);
					fails++;
				end
			end
		end
	end

	// watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if (!arst_n || (chars.valid && chars.ready) || (tokens.valid && tokens.ready)) begin
			stall_cnt <= 0;
		end else begin
			stall_cnt <= stall_cnt + 1;
			if (stall_cnt >= STALL_LIMIT) begin
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

endmodule

// ===== filelist.f =====
sv/slt_pkg.sv
sv/slt_in_if.sv
sv/slt_out_if.sv
sv/script_lexer_tokenizer.sv
dv/script_lexer_tokenizer_test.sv
